FILE: hdl/iol_pkg.sv
package iol_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_BITS = 32;
  localparam int POS_BITS = 7;
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_GET    = 2'd2;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_PAST_END = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CMP_BITS-1:0] cmp_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic  ins_en;
    logic  rem_en;
    cmp_t  ins_pos;
    cmp_t  pos;
    word_t word;
  } cell_ctl_t;

endpackage

FILE: hdl/indexed_ordered_list_top.sv
// each input transfer loads its result straight into the output register
// throughput: one operation per cycle while the output is not stalled; every cell shifts, loads or holds in parallel
// an input transfer is taken whenever the output register is empty or being drained
// reset clears the word count and the output valid; cell contents stay undefined
// until written and are never read beyond the count
module indexed_ordered_list_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [6:0]  position,
  input  logic [31:0] data_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_word,
  output logic [1:0]  status,
  output logic [6:0]  item_count
);

  iol_pkg::cnt_t      cnt;
  iol_pkg::cnt_t      cnt_next;
  iol_pkg::cmp_t      pos_c;
  iol_pkg::cmp_t      cnt_c;
  logic               accept;
  logic               full;
  logic               past;
  iol_pkg::cell_ctl_t ctl;
  iol_pkg::word_t     cell_word [iol_pkg::CAPACITY];
  iol_pkg::word_t     cell_rd [iol_pkg::CAPACITY];
  iol_pkg::word_t     rd_word;
  logic [1:0]         status_next;
  iol_pkg::word_t     res_next;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  assign pos_c = iol_pkg::cmp_t'(position);
  assign cnt_c = iol_pkg::cmp_t'(cnt);
  assign full = (cnt == iol_pkg::cnt_t'(iol_pkg::CAPACITY));
  assign past = (pos_c >= cnt_c);

  always_comb begin
    ctl.ins_en = accept && (kind == iol_pkg::KIND_INSERT) && !full;
    ctl.rem_en = accept && (kind == iol_pkg::KIND_REMOVE) && !past;
    ctl.ins_pos = past ? cnt_c : pos_c;
    ctl.pos = pos_c;
    ctl.word = iol_pkg::word_t'(data_word);
  end

  for (genvar g = 0; g < iol_pkg::CAPACITY; g++) begin : g_cell
    iol_pkg::word_t left_w;
    iol_pkg::word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == iol_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    iol_cell u_cell (
      .clk   (clk),
      .idx   (iol_pkg::cmp_t'(g)),
      .ctl   (ctl),
      .left  (left_w),
      .right (right_w),
      .word  (cell_word[g]),
      .rd    (cell_rd[g])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < iol_pkg::CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    cnt_next = cnt;
    status_next = iol_pkg::ST_DONE;
    res_next = '0;
    case (kind)
      iol_pkg::KIND_INSERT: begin
        if (full) begin
          status_next = iol_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + iol_pkg::cnt_t'(1);
        end
      end
      iol_pkg::KIND_REMOVE: begin
        if (past) begin
          status_next = iol_pkg::ST_PAST_END;
        end else begin
          res_next = rd_word;
          cnt_next = cnt - iol_pkg::cnt_t'(1);
        end
      end
      iol_pkg::KIND_GET: begin
        if (past) begin
          status_next = iol_pkg::ST_PAST_END;
        end else begin
          res_next = rd_word;
        end
      end
      default: begin
        status_next = iol_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt <= cnt_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_word <= 32'(res_next);
      status <= status_next;
      item_count <= 7'(cnt_next);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= iol_pkg::cnt_t'(iol_pkg::CAPACITY))
    else $error("word count above capacity");

  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("transfer accepted without a result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == iol_pkg::KIND_INSERT) && full |=>
      (status == iol_pkg::ST_FULL) && $stable(cnt))
    else $error("insert into full list changed state");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctl.ins_en |=> cnt == $past(cnt) + iol_pkg::cnt_t'(1))
    else $error("insert did not grow the list");
`endif

endmodule

FILE: hdl/iol_cell.sv
module iol_cell (
  input  logic               clk,
  input  iol_pkg::cmp_t      idx,
  input  iol_pkg::cell_ctl_t ctl,
  input  iol_pkg::word_t     left,
  input  iol_pkg::word_t     right,
  output iol_pkg::word_t     word,
  output iol_pkg::word_t     rd
);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (idx == ctl.ins_pos) begin
        word <= ctl.word;
      end else if (idx > ctl.ins_pos) begin
        word <= left;
      end
    end else if (ctl.rem_en) begin
      if (idx >= ctl.pos) begin
        word <= right;
      end
    end
  end

  assign rd = (idx == ctl.pos) ? word : '0;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS = 1830;
  localparam int MODE_BLOCK = 120;
  localparam int SCRIPT_LEN = 21;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  st;
    logic [6:0]  cnt;
  } answer_t;

  typedef struct packed {
    logic [1:0]  k;
    logic [6:0]  p;
    logic [31:0] w;
    logic        typed;
    answer_t     ans;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = iol_pkg::KIND_INSERT;
  logic [6:0]  position = 7'd0;
  logic [31:0] data_word = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_word;
  logic [1:0]  status;
  logic [6:0]  item_count;

  logic        row_typed = 1'b0;
  answer_t     row_answer = '0;

  logic [31:0] slots [iol_pkg::CAPACITY];
  int          list_len = 0;
  answer_t     pending_answers [$];
  row_t        script [SCRIPT_LEN];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int op_total = 0;

  indexed_ordered_list_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .position(position),
    .data_word(data_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_word(result_word),
    .status(status),
    .item_count(item_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic answer_t apply_op(logic [1:0] k, logic [6:0] p, logic [31:0] w);
    answer_t a;
    int at;
    a = '0;
    a.st = iol_pkg::ST_DONE;
    case (k)
      iol_pkg::KIND_INSERT: begin
        if (list_len >= iol_pkg::CAPACITY) begin
          a.st = iol_pkg::ST_FULL;
        end else begin
          at = (int'(p) > list_len) ? list_len : int'(p);
          for (int i = list_len; i > at; i--) slots[i] = slots[i-1];
          slots[at] = w;
          list_len++;
        end
      end
      iol_pkg::KIND_REMOVE: begin
        if (int'(p) >= list_len) begin
          a.st = iol_pkg::ST_PAST_END;
        end else begin
          a.word = slots[p];
          for (int i = int'(p); i + 1 < list_len; i++) slots[i] = slots[i+1];
          list_len--;
        end
      end
      iol_pkg::KIND_GET: begin
        if (int'(p) >= list_len) a.st = iol_pkg::ST_PAST_END;
        else a.word = slots[p];
      end
      default: ;
    endcase
    a.cnt = list_len[6:0];
    return a;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_op(input logic [1:0] k, input logic [6:0] p, input logic [31:0] w,
                         input logic typed, input answer_t ans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    data_word <= w;
    row_typed <= typed;
    row_answer <= ans;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // mode 0 fills, 1 mixes, 2 drains
  task automatic send_random(input int mode);
    int r;
    logic [1:0] k;
    logic [6:0] p;
    logic [31:0] w;
    r = $urandom_range(99);
    case (mode)
      0: k = (r < 80) ? iol_pkg::KIND_INSERT : (r < 90) ? iol_pkg::KIND_REMOVE :
             (r < 98) ? iol_pkg::KIND_GET : KIND_UNUSED;
      1: k = (r < 35) ? iol_pkg::KIND_INSERT : (r < 65) ? iol_pkg::KIND_REMOVE :
             (r < 98) ? iol_pkg::KIND_GET : KIND_UNUSED;
      default:
        k = (r < 15) ? iol_pkg::KIND_INSERT : (r < 85) ? iol_pkg::KIND_REMOVE :
            (r < 98) ? iol_pkg::KIND_GET : KIND_UNUSED;
    endcase
    r = $urandom_range(99);
    if (r < 70) begin
      if (k == iol_pkg::KIND_INSERT || list_len == 0) p = 7'($urandom_range(list_len));
      else p = 7'($urandom_range(list_len - 1));
    end else if (r < 80) begin
      p = list_len[6:0];
    end else if (r < 88) begin
      p = 7'd64;
    end else begin
      p = 7'($urandom_range(64));
    end
    r = $urandom_range(99);
    w = (r < 5) ? 32'd0 : (r < 10) ? 32'hFFFF_FFFF : $urandom;
    send_op(k, p, w, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_ports
    answer_t got;
    answer_t want;
    answer_t pred;
    if (!rst && out_valid && !out_stall) begin
      got = '{result_word, status, item_count};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: word %h status %0d count %0d",
                   got.word, got.st, got.cnt);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected word %h status %0d count %0d, ",
                      "got word %h status %0d count %0d"},
                     want.word, want.st, want.cnt, got.word, got.st, got.cnt);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      pred = apply_op(kind, position, data_word);
      pending_answers.push_back(row_typed ? row_answer : pred);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    script[0]  = '{iol_pkg::KIND_GET,    7'd0,  32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_PAST_END, 7'd0}};
    script[1]  = '{iol_pkg::KIND_REMOVE, 7'd64, 32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_PAST_END, 7'd0}};
    script[2]  = '{KIND_UNUSED,          7'd5,  32'h0000_1234, 1'b1,
                   '{32'd0, iol_pkg::ST_DONE, 7'd0}};
    script[3]  = '{iol_pkg::KIND_INSERT, 7'd64, 32'hFFFF_FFFF, 1'b1,
                   '{32'd0, iol_pkg::ST_DONE, 7'd1}};
    script[4]  = '{iol_pkg::KIND_INSERT, 7'd0,  32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_DONE, 7'd2}};
    script[5]  = '{iol_pkg::KIND_INSERT, 7'd1,  32'hA5A5_5A5A, 1'b0, '0};
    script[6]  = '{iol_pkg::KIND_INSERT, 7'd2,  32'h8000_0001, 1'b0, '0};
    script[7]  = '{iol_pkg::KIND_GET,    7'd0,  32'hFFFF_FFFF, 1'b0, '0};
    script[8]  = '{iol_pkg::KIND_GET,    7'd3,  32'd0,         1'b0, '0};
    script[9]  = '{iol_pkg::KIND_GET,    7'd4,  32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_PAST_END, 7'd4}};
    script[10] = '{iol_pkg::KIND_REMOVE, 7'd1,  32'd0,         1'b0, '0};
    script[11] = '{iol_pkg::KIND_REMOVE, 7'd3,  32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_PAST_END, 7'd3}};
    script[12] = '{KIND_UNUSED,          7'd64, 32'hFFFF_FFFF, 1'b1,
                   '{32'd0, iol_pkg::ST_DONE, 7'd3}};
    script[13] = '{iol_pkg::KIND_REMOVE, 7'd2,  32'd0,         1'b0, '0};
    script[14] = '{iol_pkg::KIND_REMOVE, 7'd0,  32'd0,         1'b0, '0};
    script[15] = '{iol_pkg::KIND_GET,    7'd0,  32'd0,         1'b0, '0};
    script[16] = '{iol_pkg::KIND_REMOVE, 7'd0,  32'd0,         1'b0, '0};
    script[17] = '{iol_pkg::KIND_GET,    7'd0,  32'd0,         1'b1,
                   '{32'd0, iol_pkg::ST_PAST_END, 7'd0}};
    script[18] = '{iol_pkg::KIND_INSERT, 7'd0,  32'h7FFF_FFFF, 1'b0, '0};
    script[19] = '{iol_pkg::KIND_INSERT, 7'd63, 32'h0000_0001, 1'b0, '0};
    script[20] = '{iol_pkg::KIND_GET,    7'd1,  32'd0,         1'b0, '0};

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      send_op(script[i].k, script[i].p, script[i].w, script[i].typed, script[i].ans);

    // idling phases: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 15 : 0;
      recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 15 : 0;
      for (int n = 0; n < RANDOM_OPS / 4; n++) begin
        send_random((op_total / MODE_BLOCK) % 3);
        op_total++;
      end
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hdl/iol_pkg.sv
hdl/iol_cell.sv
hdl/indexed_ordered_list_top.sv
tb/tb.sv
